/* src/assert_macros.svh */
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pts_pkg.sv */
// Shared types and constants of the priority thread scheduler.
package pts_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned PRIO_W  = 6;
  localparam int unsigned SLICE_W = 8;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ERR_W   = 2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;
  localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'd255;

  typedef enum logic [FUNC_W-1:0] {
    F_CREATE  = 3'd0,
    F_UNBLOCK = 3'd1,
    F_BLOCK   = 3'd2,
    F_YIELD   = 3'd3,
    F_TICK    = 3'd4,
    F_EXIT    = 3'd5,
    F_SETPRIO = 3'd6
  } func_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_NOT_BLOCKED = 2'd1,
    ERR_NO_RUNNING  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN_GO,
    S_SCAN,
    S_PICK_GO,
    S_PICK,
    S_DONE
  } st_e;

  // One ready queue entry.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Token that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic              go;
    logic              seen;
    logic [PRIO_W-1:0] best;
    entry_t            popped;
  } tok_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic              push;
    logic              pick;
    entry_t            push_ent;
    logic [PRIO_W-1:0] best;
  } cell_ctrl_t;

  // Decode of one event in the lookup cycle.
  typedef struct packed {
    logic scan;
    logic cmp;
    logic sw;
    err_e err;
    logic push_new;
    logic push_cur;
    logic set_act;
    logic clr_act;
    logic ram_we;
    logic ram_to_cur;
    logic set_prio;
    logic slice_upd;
  } lookup_t;

endpackage

/* src/pts_ifs.sv */
// Handshake channel interfaces of the scheduler: event requests, results, config.
interface pts_req_if;
  logic                        valid;
  logic                        ready;
  logic [pts_pkg::FUNC_W-1:0]  func;
  logic [pts_pkg::SLOT_W-1:0]  thread_id;
  logic [pts_pkg::PRIO_W-1:0]  priority_req;

  modport source (output valid, func, thread_id, priority_req, input ready);
  modport sink   (input valid, func, thread_id, priority_req, output ready);
endinterface

interface pts_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pts_pkg::SLOT_W-1:0]  running_id;
  logic                        running_idle;
  logic [pts_pkg::PRIO_W-1:0]  running_priority;
  logic                        switched;
  logic [pts_pkg::CNT_W-1:0]   ready_count;
  logic [pts_pkg::ERR_W-1:0]   error;

  modport source (output valid, running_id, running_idle, running_priority, switched,
                  ready_count, error, input ready);
  modport sink   (input valid, running_id, running_idle, running_priority, switched,
                  ready_count, error, output ready);
endinterface

interface pts_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pts_pkg::SLICE_W-1:0] slice_len;

  modport source (output valid, slice_len, input ready);
  modport sink   (input valid, slice_len, output ready);
endinterface

/* src/pts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pts_cell.sv */
// One ready queue cell: holds an entry, passes the scan/pick token to its neighbor.
module pts_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned LEN_W = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pts_pkg::cell_ctrl_t ctrl_i,
  input  logic [LEN_W-1:0]    len_i,
  input  pts_pkg::entry_t     next_i,
  input  pts_pkg::tok_t       tok_i,
  output pts_pkg::entry_t     ent_o,
  output pts_pkg::tok_t       tok_o
);

  pts_pkg::entry_t ent_q, ent_d;
  pts_pkg::tok_t   tok_q, tok_d;
  logic                       live;
  logic [pts_pkg::PRIO_W-1:0] own;
  logic                       hit;

  assign live = (LEN_W'(IDX) < len_i);
  assign own  = live ? ent_q.prio : '0;
  assign hit  = ctrl_i.pick && tok_i.go && live && !tok_i.seen
                && (ent_q.prio == ctrl_i.best);

  always_comb begin
    ent_d = ent_q;
    tok_d = tok_i;
    if (tok_i.go) begin
      if (ctrl_i.pick) begin
        // take the first top-priority entry out, close the gap behind it
        tok_d.seen = tok_i.seen | hit;
        if (hit) begin
          tok_d.popped = ent_q;
        end
        if (tok_i.seen || hit) begin
          ent_d = next_i;
        end
      end else if (own > tok_i.best) begin
        tok_d.best = own;
      end
    end
    if (ctrl_i.push && (len_i == LEN_W'(IDX))) begin
      ent_d = ctrl_i.push_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign ent_o = ent_q;
  assign tok_o = tok_q;

endmodule

/* src/priority_thread_scheduler.sv */
// Top level of the priority thread scheduler: event sequencer, thread tables, cell chain.
//
// Preemptive priority scheduler driven by one event request at a time (create,
// unblock, block, yield, tick, exit, set priority); each request returns one
// result with the running thread, its priority, a switch flag, the ready count
// and an error code. The ready queue is a chain of NUM_THREADS cells kept in
// FIFO order. Choosing the next thread sends a token down the chain twice: the
// first pass finds the highest ready priority, the second removes the first
// entry that carries it and shifts the entries behind it one cell forward.
// Sequencing: a request that needs no queue pass (errors, unblock while a thread
// runs, a tick inside the slice) goes from lookup straight to done, where its
// result is registered; a create or set priority that keeps the running thread
// adds a scan pass; a request that picks a new thread adds a scan and a pick pass.
// The cell chain length sets the length of each pass. The next request is accepted
// in the cycle after the result is registered at the earliest. A new request
// is taken once the previous one has moved into the result register, even
// while that result still waits. The time slice register can be written at any
// time the block is idle; it is applied at the next tick.
`include "assert_macros.svh"

module priority_thread_scheduler #(
  parameter int unsigned NUM_THREADS = 16,
  parameter int unsigned PRIO_LEVELS = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  pts_req_if.sink    req_i,
  pts_rsp_if.source  rsp_o,
  pts_cfg_if.sink    cfg_i
);

  localparam int unsigned LEN_W  = $clog2(NUM_THREADS + 1);
  localparam int unsigned TIDX_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

  localparam logic [pts_pkg::PRIO_W-1:0] PRIO_TOP = pts_pkg::PRIO_W'(PRIO_LEVELS - 1);

  // sequencer state
  pts_pkg::st_e state_q, state_d;

  // latched request
  logic [pts_pkg::FUNC_W-1:0] func_q;
  logic [pts_pkg::SLOT_W-1:0] tid_q;
  logic [pts_pkg::PRIO_W-1:0] prio_q;
  logic                       cmp_q;
  logic                       sw_q;
  pts_pkg::err_e              err_q;

  // scheduler state
  logic [LEN_W-1:0]            len_q, len_d;
  logic [pts_pkg::SLOT_W-1:0]  cur_q;
  logic [pts_pkg::PRIO_W-1:0]  cur_prio_q;
  logic                        idle_q;
  logic [pts_pkg::SLICE_W-1:0] slice_q;
  logic [pts_pkg::SLICE_W-1:0] ts_q;
  logic [NUM_THREADS-1:0]      active_q, active_d;
  logic [NUM_THREADS-1:0]      pv_q, pv_d;
  logic [pts_pkg::PRIO_W-1:0]  best_q;

  // result register
  logic                        rsp_valid_q;
  logic [pts_pkg::SLOT_W-1:0]  rsp_id_q;
  logic                        rsp_idle_q;
  logic [pts_pkg::PRIO_W-1:0]  rsp_prio_q;
  logic                        rsp_sw_q;
  logic [pts_pkg::CNT_W-1:0]   rsp_cnt_q;
  logic [pts_pkg::ERR_W-1:0]   rsp_err_q;

  // decode and control
  logic                        req_fire;
  logic                        rsp_free;
  logic [TIDX_W-1:0]           tid_idx;
  logic [TIDX_W-1:0]           cur_idx;
  logic                        tid_ok;
  logic                        blocked;
  logic [pts_pkg::PRIO_W-1:0]  new_prio;
  logic [pts_pkg::PRIO_W-1:0]  ram_rdata;
  logic [pts_pkg::SLICE_W-1:0] slice_inc;
  logic [pts_pkg::PRIO_W-1:0]  req_prio_sat;
  pts_pkg::lookup_t            lk;
  logic                        scan_end;
  logic                        pick_end;
  logic                        scan_hi;
  logic                        ram_we;
  logic [TIDX_W-1:0]           ram_waddr;

  // cell chain
  pts_pkg::cell_ctrl_t ctrl;
  pts_pkg::tok_t       tok_start;
  pts_pkg::entry_t     ent   [NUM_THREADS];
  pts_pkg::tok_t       tok   [NUM_THREADS];
  pts_pkg::tok_t       tok_last;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == pts_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign req_prio_sat = (32'(req_i.priority_req) >= PRIO_LEVELS) ? PRIO_TOP
                                                                 : req_i.priority_req;

  assign tid_idx   = TIDX_W'(tid_q);
  assign cur_idx   = TIDX_W'(cur_q);
  assign tid_ok    = (32'(tid_q) < NUM_THREADS);
  assign blocked   = tid_ok && !active_q[tid_idx];
  assign new_prio  = (func_q == pts_pkg::F_CREATE) ? prio_q
                                                   : (pv_q[tid_idx] ? ram_rdata : '0);
  assign slice_inc = (slice_q == pts_pkg::SLICE_MAX) ? slice_q
                                                     : slice_q + pts_pkg::SLICE_W'(1);

  assign tok_last = tok[NUM_THREADS-1];
  assign scan_end = (state_q == pts_pkg::S_SCAN) && tok_last.go;
  assign pick_end = (state_q == pts_pkg::S_PICK) && tok_last.go;
  assign scan_hi  = (tok_last.best > cur_prio_q);

  // Decode the latched request against the thread tables.
  always_comb begin
    lk     = '0;
    lk.err = pts_pkg::ERR_OK;
    case (pts_pkg::func_e'(func_q))
      pts_pkg::F_CREATE, pts_pkg::F_UNBLOCK: begin
        if (!blocked) begin
          lk.err = pts_pkg::ERR_NOT_BLOCKED;
        end else begin
          lk.push_new = 1'b1;
          lk.set_act  = 1'b1;
          lk.ram_we   = (func_q == pts_pkg::F_CREATE);
          if (idle_q) begin
            // idle never runs next to a ready thread: choose at once
            lk.scan = 1'b1;
            lk.sw   = 1'b1;
          end else if (func_q == pts_pkg::F_CREATE) begin
            lk.scan = 1'b1;
            lk.cmp  = 1'b1;
          end
        end
      end
      pts_pkg::F_BLOCK, pts_pkg::F_EXIT: begin
        if (idle_q) begin
          lk.err = pts_pkg::ERR_NO_RUNNING;
        end else begin
          lk.clr_act = 1'b1;
          lk.scan    = 1'b1;
          lk.sw      = 1'b1;
        end
      end
      pts_pkg::F_YIELD: begin
        if (idle_q) begin
          lk.err = pts_pkg::ERR_NO_RUNNING;
        end else begin
          lk.push_cur = 1'b1;
          lk.scan     = 1'b1;
          lk.sw       = 1'b1;
        end
      end
      pts_pkg::F_SETPRIO: begin
        if (idle_q) begin
          lk.err = pts_pkg::ERR_NO_RUNNING;
        end else begin
          lk.set_prio   = 1'b1;
          lk.ram_we     = 1'b1;
          lk.ram_to_cur = 1'b1;
          lk.scan       = 1'b1;
          lk.cmp        = 1'b1;
        end
      end
      pts_pkg::F_TICK: begin
        lk.slice_upd = 1'b1;
        if (slice_inc >= ts_q) begin
          // slice used up: requeue the running thread and choose again
          lk.push_cur = !idle_q;
          lk.scan     = 1'b1;
          lk.sw       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::S_IDLE: begin
        if (req_fire) begin
          state_d = pts_pkg::S_LOOKUP;
        end
      end
      pts_pkg::S_LOOKUP: begin
        state_d = lk.scan ? pts_pkg::S_SCAN_GO : pts_pkg::S_DONE;
      end
      pts_pkg::S_SCAN_GO: begin
        state_d = pts_pkg::S_SCAN;
      end
      pts_pkg::S_SCAN: begin
        if (tok_last.go) begin
          if (cmp_q) begin
            state_d = scan_hi ? pts_pkg::S_PICK_GO : pts_pkg::S_DONE;
          end else begin
            state_d = (len_q == '0) ? pts_pkg::S_DONE : pts_pkg::S_PICK_GO;
          end
        end
      end
      pts_pkg::S_PICK_GO: begin
        state_d = pts_pkg::S_PICK;
      end
      pts_pkg::S_PICK: begin
        if (tok_last.go) begin
          state_d = pts_pkg::S_DONE;
        end
      end
      pts_pkg::S_DONE: begin
        if (rsp_free) begin
          state_d = pts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pts_pkg::S_IDLE;
      end
    endcase
  end

  // Control outputs toward the cell chain and the priority table.
  always_comb begin
    ctrl          = '0;
    ctrl.best     = best_q;
    ctrl.pick     = (state_q == pts_pkg::S_PICK_GO) || (state_q == pts_pkg::S_PICK);
    tok_start     = '0;
    tok_start.go  = (state_q == pts_pkg::S_SCAN_GO) || (state_q == pts_pkg::S_PICK_GO);
    ram_we        = 1'b0;
    ram_waddr     = tid_idx;
    case (state_q)
      pts_pkg::S_LOOKUP: begin
        ram_we    = lk.ram_we;
        ram_waddr = lk.ram_to_cur ? cur_idx : tid_idx;
        if (lk.push_new) begin
          ctrl.push          = 1'b1;
          ctrl.push_ent.slot = tid_q;
          ctrl.push_ent.prio = new_prio;
        end else if (lk.push_cur) begin
          ctrl.push          = 1'b1;
          ctrl.push_ent.slot = cur_q;
          ctrl.push_ent.prio = cur_prio_q;
        end
      end
      pts_pkg::S_SCAN: begin
        // preempt: the running thread goes to the back of the queue
        if (tok_last.go && cmp_q && scan_hi) begin
          ctrl.push          = 1'b1;
          ctrl.push_ent.slot = cur_q;
          ctrl.push_ent.prio = cur_prio_q;
        end
      end
      default: begin
      end
    endcase
    // the queue never overflows: a slot sits in it at most once
    if (len_q == LEN_W'(NUM_THREADS)) begin
      ctrl.push = 1'b0;
    end
  end

  // Thread table bits and queue length.
  always_comb begin
    active_d = active_q;
    pv_d     = pv_q;
    len_d    = len_q;
    if (state_q == pts_pkg::S_LOOKUP) begin
      if (lk.set_act) begin
        active_d[tid_idx] = 1'b1;
      end
      if (lk.clr_act) begin
        active_d[cur_idx] = 1'b0;
      end
    end
    if (ram_we) begin
      pv_d[ram_waddr] = 1'b1;
    end
    if (ctrl.push) begin
      len_d = len_q + LEN_W'(1);
    end else if (pick_end) begin
      len_d = len_q - LEN_W'(1);
    end
  end

  pts_ram #(
    .WIDTH (pts_pkg::PRIO_W),
    .DEPTH (NUM_THREADS)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (prio_q),
    .re_i    (req_fire),
    .raddr_i (TIDX_W'(req_i.thread_id)),
    .rdata_o (ram_rdata)
  );

  for (genvar i = 0; i < NUM_THREADS; i++) begin : g_cell
    pts_pkg::entry_t nxt;
    pts_pkg::tok_t   tin;
    if (i == NUM_THREADS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    if (i == 0) begin : g_head
      assign tin = tok_start;
    end else begin : g_body
      assign tin = tok[i-1];
    end
    pts_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .len_i  (len_q),
      .next_i (nxt),
      .tok_i  (tin),
      .ent_o  (ent[i]),
      .tok_o  (tok[i])
    );
  end

  // Latch the request, the scan result and the result payload; these need no reset.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q <= req_i.func;
      tid_q  <= req_i.thread_id;
      prio_q <= req_prio_sat;
    end
    if (scan_end) begin
      best_q <= tok_last.best;
    end
    if (state_q == pts_pkg::S_DONE && rsp_free) begin
      rsp_id_q   <= idle_q ? '0 : cur_q;
      rsp_idle_q <= idle_q;
      rsp_prio_q <= idle_q ? '0 : cur_prio_q;
      rsp_sw_q   <= sw_q;
      rsp_cnt_q  <= pts_pkg::CNT_W'(len_q);
      rsp_err_q  <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pts_pkg::S_IDLE;
      cmp_q       <= 1'b0;
      sw_q        <= 1'b0;
      err_q       <= pts_pkg::ERR_OK;
      len_q       <= '0;
      cur_q       <= '0;
      cur_prio_q  <= '0;
      idle_q      <= 1'b1;
      slice_q     <= '0;
      ts_q        <= pts_pkg::SLICE_RESET;
      active_q    <= '0;
      pv_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      active_q <= active_d;
      pv_q     <= pv_d;
      if (cfg_i.valid) begin
        ts_q <= cfg_i.slice_len;
      end
      if (state_q == pts_pkg::S_LOOKUP) begin
        err_q <= lk.err;
        sw_q  <= lk.sw;
        cmp_q <= lk.cmp;
        if (lk.set_prio) begin
          cur_prio_q <= prio_q;
        end
        if (lk.slice_upd) begin
          slice_q <= slice_inc;
        end
      end
      if (scan_end) begin
        if (cmp_q && scan_hi) begin
          sw_q <= 1'b1;
        end
        if (!cmp_q && (len_q == '0)) begin
          // nothing ready: drop to the idle thread
          idle_q  <= 1'b1;
          cur_q   <= '0;
          slice_q <= '0;
        end
      end
      if (pick_end) begin
        cur_q      <= tok_last.popped.slot;
        cur_prio_q <= tok_last.popped.prio;
        idle_q     <= 1'b0;
        slice_q    <= '0;
      end
      if (state_q == pts_pkg::S_DONE && rsp_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.running_id       = rsp_id_q;
  assign rsp_o.running_idle     = rsp_idle_q;
  assign rsp_o.running_priority = rsp_prio_q;
  assign rsp_o.switched         = rsp_sw_q;
  assign rsp_o.ready_count      = rsp_cnt_q;
  assign rsp_o.error            = rsp_err_q;

  `PTS_ASSERT_ALWAYS(a_reset_idle, clk_i,
                     !rst_ni |-> (state_q == pts_pkg::S_IDLE),
                     "sequencer not idle in reset")
  `PTS_ASSERT(a_accept_lookup, clk_i, rst_ni,
              req_fire |=> (state_q == pts_pkg::S_LOOKUP),
              "accepted request not decoded")
  `PTS_ASSERT(a_run_active, clk_i, rst_ni,
              (state_q == pts_pkg::S_IDLE && !idle_q) |-> active_q[cur_idx],
              "running thread marked blocked")
  `PTS_ASSERT(a_idle_empty, clk_i, rst_ni,
              (state_q == pts_pkg::S_IDLE && idle_q) |-> (len_q == '0),
              "idle runs with threads ready")
  `PTS_ASSERT(a_pick_found, clk_i, rst_ni,
              pick_end |-> tok_last.seen,
              "pick pass found no entry")

endmodule
